// ===== hdl/cps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// Types and constants shared by the camera pose stepper: payload structs,
// command codes, reset values of the pose and of the configuration registers.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int PosW  = 32;
  localparam int VecW  = 16;
  localparam int FuncW = 4;
  localparam int StepW = 24;
  localparam int AddrW = 4;
  localparam int DataW = 32;

  // Command codes.
  localparam logic [FuncW-1:0] FN_FRONT    = 4'd0;
  localparam logic [FuncW-1:0] FN_BACK     = 4'd1;
  localparam logic [FuncW-1:0] FN_LEFT     = 4'd2;
  localparam logic [FuncW-1:0] FN_RIGHT    = 4'd3;
  localparam logic [FuncW-1:0] FN_UP       = 4'd4;
  localparam logic [FuncW-1:0] FN_DOWN     = 4'd5;
  localparam logic [FuncW-1:0] FN_TURN_R   = 4'd6;
  localparam logic [FuncW-1:0] FN_TURN_L   = 4'd7;
  localparam logic [FuncW-1:0] FN_TURN_U   = 4'd8;
  localparam logic [FuncW-1:0] FN_TURN_D   = 4'd9;
  localparam logic [FuncW-1:0] FN_TURN_CW  = 4'd10;
  localparam logic [FuncW-1:0] FN_TURN_CCW = 4'd11;
  localparam logic [FuncW-1:0] FN_LOAD_POS = 4'd12;
  localparam logic [FuncW-1:0] FN_LOAD_DIR = 4'd13;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MOVE_STEP = 2'd0;
  localparam logic [1:0] REG_TURN_COS  = 2'd1;
  localparam logic [1:0] REG_TURN_SIN  = 2'd2;

  localparam logic [StepW-1:0]       MOVE_STEP_RST = 24'd6554;
  localparam logic signed [VecW-1:0] TURN_COS_RST  = 16'sd16382;
  localparam logic signed [VecW-1:0] TURN_SIN_RST  = 16'sd286;
  localparam logic signed [VecW-1:0] Q14_ONE       = 16'sd16384;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic signed [PosW-1:0]  new_pos_x;
    logic signed [PosW-1:0]  new_pos_y;
    logic signed [PosW-1:0]  new_pos_z;
    logic signed [VecW-1:0]  new_dir_x;
    logic signed [VecW-1:0]  new_dir_y;
    logic signed [VecW-1:0]  new_dir_z;
    logic signed [VecW-1:0]  new_up_x;
    logic signed [VecW-1:0]  new_up_y;
    logic signed [VecW-1:0]  new_up_z;
  } in_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [VecW-1:0] dir_x;
    logic signed [VecW-1:0] dir_y;
    logic signed [VecW-1:0] dir_z;
    logic signed [VecW-1:0] up_x;
    logic signed [VecW-1:0] up_y;
    logic signed [VecW-1:0] up_z;
    logic signed [VecW-1:0] right_x;
    logic signed [VecW-1:0] right_y;
    logic signed [VecW-1:0] right_z;
  } out_t;

endpackage
`default_nettype wire

// ===== hdl/camera_pose_stepper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// camera_pose_stepper
// First-person camera pose: moves, turns and loads under command, one shared
// multiply-accumulate unit working through the vector components in turn.
// ----------------------------------------------------------------------------
// Load position and unused codes go straight to the finish state; a move runs a
// pass over the position, load direction a cross-product pass, a turn a rotation
// pass then a cross-product pass. The shared two-product multiply-accumulate unit
// handles one vector component per cycle; a command is taken again once the
// previous one has been written to the output register.
// Synchronous active-low reset restores the default pose and configuration registers.
// ----------------------------------------------------------------------------
module camera_pose_stepper (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  cps_pkg::in_t           in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output cps_pkg::out_t                out_data,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [cps_pkg::AddrW-1:0]    paddr,
  input  wire  [cps_pkg::DataW-1:0]    pwdata,
  output logic [cps_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  typedef enum logic [2:0] {S_IDLE, S_MOVE, S_ROT, S_CROSS, S_FINISH} state_t;

  state_t state_r, state_nxt;
  logic [1:0] cnt_r;
  logic [cps_pkg::FuncW-1:0] func_r;
  logic out_valid_r;
  cps_pkg::out_t out_r;

  logic [cps_pkg::StepW-1:0]       move_step_r;
  logic signed [cps_pkg::VecW-1:0] turn_cos_r, turn_sin_r;

  // Slot 0 of each vector holds the component being worked on; the vectors
  // rotate by one slot per cycle during a pass over the three components.
  logic signed [cps_pkg::PosW-1:0] pos_r   [3];
  logic signed [cps_pkg::VecW-1:0] dir_r   [3];
  logic signed [cps_pkg::VecW-1:0] up_r    [3];
  logic signed [cps_pkg::VecW-1:0] right_r [3];

  // Shared unit operands and results.
  logic signed [24:0] mul_a;
  logic signed [cps_pkg::VecW-1:0] mul_b, mul_c, mul_d;
  logic mul_sub, move_neg;
  logic tgt_pos, tgt_dir, tgt_up, tgt_right;
  logic signed [40:0] prod_p;
  logic signed [31:0] prod_q;
  logic signed [41:0] acc;
  logic signed [27:0] shr;
  logic signed [33:0] pos_sum;
  logic signed [cps_pkg::VecW-1:0] vec_res;
  logic signed [cps_pkg::PosW-1:0] pos_res;
  logic in_fire, cfg_wr, pass_end, out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign pass_end  = (cnt_r == 2'd2);
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    case (paddr[3:2])
      cps_pkg::REG_MOVE_STEP: prdata = {8'd0, move_step_r};
      cps_pkg::REG_TURN_COS:  prdata = {{16{turn_cos_r[15]}}, turn_cos_r};
      cps_pkg::REG_TURN_SIN:  prdata = {{16{turn_sin_r[15]}}, turn_sin_r};
      default:                prdata = '0;
    endcase
  end

  // Operand selection for the shared unit.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_c     = '0;
    mul_d     = '0;
    mul_sub   = 1'b0;
    move_neg  = 1'b0;
    tgt_pos   = 1'b0;
    tgt_dir   = 1'b0;
    tgt_up    = 1'b0;
    tgt_right = 1'b0;
    case (state_r)
      S_MOVE: begin
        tgt_pos = 1'b1;
        mul_a   = {1'b0, move_step_r};
        case (func_r)
          cps_pkg::FN_FRONT, cps_pkg::FN_BACK: mul_b = dir_r[0];
          cps_pkg::FN_LEFT, cps_pkg::FN_RIGHT: mul_b = right_r[0];
          default:                             mul_b = up_r[0];
        endcase
        move_neg = (func_r == cps_pkg::FN_FRONT) || (func_r == cps_pkg::FN_LEFT) ||
                   (func_r == cps_pkg::FN_DOWN);
      end
      S_ROT: begin
        mul_a   = {{9{turn_cos_r[15]}}, turn_cos_r};
        mul_c   = turn_sin_r;
        mul_sub = (func_r == cps_pkg::FN_TURN_R) || (func_r == cps_pkg::FN_TURN_U) ||
                  (func_r == cps_pkg::FN_TURN_CCW);
        if ((func_r == cps_pkg::FN_TURN_CW) || (func_r == cps_pkg::FN_TURN_CCW)) begin
          tgt_up = 1'b1;
          mul_b  = up_r[0];
          mul_d  = right_r[0];
        end else begin
          tgt_dir = 1'b1;
          mul_b   = dir_r[0];
          if ((func_r == cps_pkg::FN_TURN_U) || (func_r == cps_pkg::FN_TURN_D)) begin
            mul_d = up_r[0];
          end else begin
            mul_d = right_r[0];
          end
        end
      end
      S_CROSS: begin
        // out[i] = a[i+1]*b[i+2] - b[i+1]*a[i+2]
        mul_sub = 1'b1;
        if ((func_r == cps_pkg::FN_TURN_U) || (func_r == cps_pkg::FN_TURN_D)) begin
          tgt_up = 1'b1;
          mul_a  = {{9{dir_r[1][15]}}, dir_r[1]};
          mul_b  = right_r[2];
          mul_c  = right_r[1];
          mul_d  = dir_r[2];
        end else begin
          tgt_right = 1'b1;
          mul_a     = {{9{up_r[1][15]}}, up_r[1]};
          mul_b     = dir_r[2];
          mul_c     = dir_r[1];
          mul_d     = up_r[2];
        end
      end
      default: begin
      end
    endcase
  end

  assign prod_p = mul_a * mul_b;
  assign prod_q = mul_c * mul_d;

  always_comb begin
    if (mul_sub) begin
      acc = {prod_p[40], prod_p} - {{10{prod_q[31]}}, prod_q};
    end else begin
      acc = {prod_p[40], prod_p} + {{10{prod_q[31]}}, prod_q};
    end
    // Dropping the low bits is a floor shift for two's complement.
    shr = acc[41:14];
    if (shr > 28'sd32767) begin
      vec_res = 16'sh7FFF;
    end else if (shr < -28'sd32768) begin
      vec_res = 16'sh8000;
    end else begin
      vec_res = shr[15:0];
    end
    if (move_neg) begin
      pos_sum = {{2{pos_r[0][31]}}, pos_r[0]} - {{6{shr[27]}}, shr};
    end else begin
      pos_sum = {{2{pos_r[0][31]}}, pos_r[0]} + {{6{shr[27]}}, shr};
    end
    if (pos_sum > 34'sh07FFFFFFF) begin
      pos_res = 32'sh7FFFFFFF;
    end else if (pos_sum < -34'sh080000000) begin
      pos_res = 32'sh80000000;
    end else begin
      pos_res = pos_sum[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.func <= cps_pkg::FN_DOWN) begin
            state_nxt = S_MOVE;
          end else if (in_data.func <= cps_pkg::FN_TURN_CCW) begin
            state_nxt = S_ROT;
          end else if (in_data.func == cps_pkg::FN_LOAD_DIR) begin
            state_nxt = S_CROSS;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_MOVE:   if (pass_end) state_nxt = S_FINISH;
      S_ROT:    if (pass_end) state_nxt = S_CROSS;
      S_CROSS:  if (pass_end) state_nxt = S_FINISH;
      S_FINISH: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
      move_step_r <= cps_pkg::MOVE_STEP_RST;
      turn_cos_r  <= cps_pkg::TURN_COS_RST;
      turn_sin_r  <= cps_pkg::TURN_SIN_RST;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      pos_r[2]    <= '0;
      dir_r[0]    <= '0;
      dir_r[1]    <= '0;
      dir_r[2]    <= cps_pkg::Q14_ONE;
      up_r[0]     <= '0;
      up_r[1]     <= cps_pkg::Q14_ONE;
      up_r[2]     <= '0;
      right_r[0]  <= cps_pkg::Q14_ONE;
      right_r[1]  <= '0;
      right_r[2]  <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (paddr[3:2])
          cps_pkg::REG_MOVE_STEP: move_step_r <= pwdata[23:0];
          cps_pkg::REG_TURN_COS:  turn_cos_r  <= pwdata[15:0];
          cps_pkg::REG_TURN_SIN:  turn_sin_r  <= pwdata[15:0];
          default: begin
          end
        endcase
      end

      if (in_fire) begin
        func_r <= in_data.func;
        cnt_r  <= 2'd0;
        if (in_data.func == cps_pkg::FN_LOAD_POS) begin
          pos_r[0] <= in_data.new_pos_x;
          pos_r[1] <= in_data.new_pos_y;
          pos_r[2] <= in_data.new_pos_z;
        end
        if (in_data.func == cps_pkg::FN_LOAD_DIR) begin
          dir_r[0] <= in_data.new_dir_x;
          dir_r[1] <= in_data.new_dir_y;
          dir_r[2] <= in_data.new_dir_z;
          up_r[0]  <= in_data.new_up_x;
          up_r[1]  <= in_data.new_up_y;
          up_r[2]  <= in_data.new_up_z;
        end
      end

      if ((state_r == S_MOVE) || (state_r == S_ROT) || (state_r == S_CROSS)) begin
        cnt_r      <= pass_end ? 2'd0 : cnt_r + 2'd1;
        pos_r[0]   <= pos_r[1];
        pos_r[1]   <= pos_r[2];
        pos_r[2]   <= tgt_pos ? pos_res : pos_r[0];
        dir_r[0]   <= dir_r[1];
        dir_r[1]   <= dir_r[2];
        dir_r[2]   <= tgt_dir ? vec_res : dir_r[0];
        up_r[0]    <= up_r[1];
        up_r[1]    <= up_r[2];
        up_r[2]    <= tgt_up ? vec_res : up_r[0];
        right_r[0] <= right_r[1];
        right_r[1] <= right_r[2];
        right_r[2] <= tgt_right ? vec_res : right_r[0];
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (out_load) begin
      out_r.pos_x   <= pos_r[0];
      out_r.pos_y   <= pos_r[1];
      out_r.pos_z   <= pos_r[2];
      out_r.dir_x   <= dir_r[0];
      out_r.dir_y   <= dir_r[1];
      out_r.dir_z   <= dir_r[2];
      out_r.up_x    <= up_r[0];
      out_r.up_y    <= up_r[1];
      out_r.up_z    <= up_r[2];
      out_r.right_x <= right_r[0];
      out_r.right_y <= right_r[1];
      out_r.right_z <= right_r[2];
    end
  end

  // A command blocks the input until it is finished.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input ready right after a transfer");

  // The component counter never passes the last component.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("component counter out of range");

  // A position load lands in the pose registers on the next cycle.
  a_load_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.func == cps_pkg::FN_LOAD_POS)) |=>
      (pos_r[0] == $past(in_data.new_pos_x)) && (state_r == S_FINISH))
    else $error("position load not taken");

  // The output register is only written when it is free or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && state_r == S_FINISH) |=> (state_r == S_FINISH))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
